// ----- hw/rtl/pws_pkg.sv -----
// ---------------------------------------------------------------------------
// pws_pkg: shared types, constants and functions for the projection unit
// Fixed-point widths, register indexes, divider cell types and the arithmetic
// helpers used by the front end, the divider cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

	// Fixed-point format and derived widths
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int ACC_W     = PROD_W + 2 - FRAC_BITS;
	localparam int SIZE_W    = 14;
	localparam int SHIFT     = FRAC_BITS - 1;
	localparam int MP_W      = ACC_W + SIZE_W;
	localparam int NUM_W     = MP_W + SHIFT;
	localparam int Q_W       = 34;
	localparam int REM0_W    = NUM_W - Q_W;
	localparam int HALF_W    = SIZE_W + SHIFT;
	localparam int SUM_W     = Q_W + 2;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;

	// Near-plane threshold, rounded to the fixed-point grid
	localparam longint W_MIN_VAL = ((64'sd1 <<< FRAC_BITS) + 500) / 1000;
	localparam logic signed [ACC_W-1:0] W_MIN = ACC_W'(W_MIN_VAL);

	// Behind-viewer scaling and its saturation limits
	localparam int BEHIND_SCALE = 100000;
	localparam int BEHIND_LIM   = 2147483647 / BEHIND_SCALE;
	localparam logic signed [ACC_W-1:0] LIM_P = ACC_W'(BEHIND_LIM);
	localparam logic signed [ACC_W-1:0] LIM_N = -LIM_P;
	localparam logic signed [COORD_W-1:0] SCALE_C = COORD_W'(BEHIND_SCALE);

	// Output saturation bounds at the final sum width
	localparam logic signed [SUM_W-1:0] S_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SUM_W-1:0] S_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_XY = 4'd0,
		REG_ROW0_ZT = 4'd1,
		REG_ROW1_XY = 4'd2,
		REG_ROW1_ZT = 4'd3,
		REG_ROW3_XY = 4'd4,
		REG_ROW3_ZT = 4'd5,
		REG_VIEW_W  = 4'd6,
		REG_VIEW_H  = 4'd7
	} cfg_reg_t;

	// Configuration image handed to the front end
	typedef struct packed {
		logic [CFG_DATA_W-1:0] r0xy;
		logic [CFG_DATA_W-1:0] r0zt;
		logic [CFG_DATA_W-1:0] r1xy;
		logic [CFG_DATA_W-1:0] r1zt;
		logic [CFG_DATA_W-1:0] r3xy;
		logic [CFG_DATA_W-1:0] r3zt;
		logic [SIZE_W-1:0]     vw;
		logic [SIZE_W-1:0]     vh;
	} cfg_t;

	// One divider lane: partial remainder, pending dividend bits, quotient
	typedef struct packed {
		logic [ACC_W-1:0] rem;
		logic [Q_W-1:0]   num;
		logic [Q_W-1:0]   quo;
	} lane_t;

	// Values that ride along with the division
	typedef struct packed {
		logic               on;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
		logic               negx;
		logic               negy;
		logic [HALF_W-1:0]  halfx;
		logic [HALF_W-1:0]  halfy;
		logic               bigx;
		logic               bigy;
		logic [ACC_W-1:0]   w;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		lane_t lx;
		lane_t ly;
	} cell_t;

	// One restoring-division step: one quotient bit
	function automatic lane_t div_step(input lane_t l, input logic [ACC_W-1:0] w);
		logic [ACC_W:0] t;
		logic           qb;
		lane_t          r;
		t  = {l.rem, l.num[Q_W-1]};
		qb = 1'b0;
		if (t >= {1'b0, w}) begin
			t  = t - {1'b0, w};
			qb = 1'b1;
		end
		r.rem = t[ACC_W-1:0];
		r.num = {l.num[Q_W-2:0], 1'b0};
		r.quo = {l.quo[Q_W-2:0], qb};
		return r;
	endfunction

	// Clip coordinate scaled for a point behind the viewer, saturated
	function automatic logic [COORD_W-1:0] behind_axis(input logic signed [ACC_W-1:0] c);
		logic signed [COORD_W-1:0] cs;
		logic signed [COORD_W-1:0] r;
		cs = {{(COORD_W-16){c[15]}}, c[15:0]};
		if (c > LIM_P) begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (c < LIM_N) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = cs * SCALE_C;
		end
		return r;
	endfunction

	// Viewport center plus or minus the quotient, saturated
	function automatic logic [COORD_W-1:0] map_sat(input logic [HALF_W-1:0] half,
		input logic [Q_W-1:0] q, input logic neg, input logic big);
		logic signed [SUM_W-1:0] hh;
		logic signed [SUM_W-1:0] qq;
		logic signed [SUM_W-1:0] s;
		logic [COORD_W-1:0]      r;
		hh = SUM_W'(half);
		qq = big ? {2'b00, {Q_W{1'b1}}} : {2'b00, q};
		s  = neg ? (hh - qq) : (hh + qq);
		if (s > S_MAX) begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (s < S_MIN) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = s[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/perspective_world_to_screen_unit.sv -----
// ---------------------------------------------------------------------------
// perspective_world_to_screen_unit: world point to screen pixel projection
// Configuration registers, front end, divider chain and output register.
// ---------------------------------------------------------------------------
// Accepts one point per clock and returns one result per point, in order.
// The pipeline has three front-end stages (products, clip sums, near-
// plane test and viewport products), a chain of 34 divider cells that each
// resolve one quotient bit of x/w and y/w, and the output register. A stall
// on the output holds the whole pipeline. Write the configuration registers
// only while no transaction is in flight.
`default_nettype none

module perspective_world_to_screen_unit import pws_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_W-1:0]    point_x,
	input  wire logic [COORD_W-1:0]    point_y,
	input  wire logic [COORD_W-1:0]    point_z,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [COORD_W-1:0]         screen_x,
	output logic [COORD_W-1:0]         screen_y,
	output logic                       on_screen
);

	cfg_t               cfg_q;
	logic               adv;
	logic               chain_v [Q_W+1];
	cell_t              chain_c [Q_W+1];
	cell_t              last_c;
	logic               out_valid_q;
	logic [COORD_W-1:0] sx_q, sy_q;
	logic               on_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r0xy <= '0;
			cfg_q.r0zt <= '0;
			cfg_q.r1xy <= '0;
			cfg_q.r1zt <= '0;
			cfg_q.r3xy <= '0;
			cfg_q.r3zt <= '0;
			cfg_q.vw   <= SIZE_W'(1920);
			cfg_q.vh   <= SIZE_W'(1080);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW0_XY: cfg_q.r0xy <= cfg_data;
				REG_ROW0_ZT: cfg_q.r0zt <= cfg_data;
				REG_ROW1_XY: cfg_q.r1xy <= cfg_data;
				REG_ROW1_ZT: cfg_q.r1zt <= cfg_data;
				REG_ROW3_XY: cfg_q.r3xy <= cfg_data;
				REG_ROW3_ZT: cfg_q.r3zt <= cfg_data;
				REG_VIEW_W:  cfg_q.vw   <= cfg_data[SIZE_W-1:0];
				REG_VIEW_H:  cfg_q.vh   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless a finished result is held
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	pws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.px         (point_x),
		.py         (point_y),
		.pz         (point_z),
		.cfg        (cfg_q),
		.seed_valid (chain_v[0]),
		.seed       (chain_c[0])
	);

	// Divider chain, one quotient bit per cell
	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		pws_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.d_valid (chain_v[i]),
			.d       (chain_c[i]),
			.q_valid (chain_v[i+1]),
			.q       (chain_c[i+1])
		);
	end

	assign last_c = chain_c[Q_W];

	// Output register: viewport mapping or behind-viewer values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			on_q <= last_c.meta.on;
			sx_q <= last_c.meta.on
				? map_sat(last_c.meta.halfx, last_c.lx.quo, last_c.meta.negx, last_c.meta.bigx)
				: last_c.meta.bx;
			sy_q <= last_c.meta.on
				? map_sat(last_c.meta.halfy, last_c.ly.quo, last_c.meta.negy, last_c.meta.bigy)
				: last_c.meta.by;
		end
	end

	assign out_valid = out_valid_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;
	assign on_screen = on_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pws_front.sv -----
// ---------------------------------------------------------------------------
// pws_front: matrix products, clip sums and near-plane classification
// Three stages: nine coefficient products, the three clip sums, then the
// near-plane test, viewport products and the seed of the divider chain.
// ---------------------------------------------------------------------------
`default_nettype none

module pws_front import pws_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [COORD_W-1:0] px,
	input  wire logic [COORD_W-1:0] py,
	input  wire logic [COORD_W-1:0] pz,
	input  wire cfg_t               cfg,
	output logic                    seed_valid,
	output cell_t                   seed
);

	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [PROD_W-1:0]  prod_s1 [9];
	logic signed [COORD_W-1:0] trans_s1 [3];
	logic signed [ACC_W-1:0]   acc_s2 [3];
	logic signed [ACC_W-1:0]   acc_c [3];
	logic [CFG_DATA_W-1:0]     xy_c [3];
	logic [CFG_DATA_W-1:0]     zt_c [3];

	logic                      behind_c;
	logic [ACC_W-1:0]          magx_c, magy_c;
	logic                      on_s3, negx_s3, negy_s3;
	logic [COORD_W-1:0]        bx_s3, by_s3;
	logic [HALF_W-1:0]         halfx_s3, halfy_s3;
	logic [MP_W-1:0]           prodx_s3, prody_s3;
	logic [ACC_W-1:0]          w_s3;

	// Gather the three used matrix rows
	assign xy_c[0] = cfg.r0xy;
	assign xy_c[1] = cfg.r1xy;
	assign xy_c[2] = cfg.r3xy;
	assign zt_c[0] = cfg.r0zt;
	assign zt_c[1] = cfg.r1zt;
	assign zt_c[2] = cfg.r3zt;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: exact coefficient products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= $signed(xy_c[r][COORD_W-1:0]) * $signed(px);
				prod_s1[3*r+1] <= $signed(xy_c[r][CFG_DATA_W-1:COORD_W]) * $signed(py);
				prod_s1[3*r+2] <= $signed(zt_c[r][COORD_W-1:0]) * $signed(pz);
				trans_s1[r]    <= $signed(zt_c[r][CFG_DATA_W-1:COORD_W]);
			end
		end
	end

	// Stage 2: floor-shift the products and sum with the translation
	always_comb begin
		logic signed [PROD_W-1:0] sh0, sh1, sh2;
		for (int r = 0; r < 3; r++) begin
			sh0 = prod_s1[3*r] >>> FRAC_BITS;
			sh1 = prod_s1[3*r+1] >>> FRAC_BITS;
			sh2 = prod_s1[3*r+2] >>> FRAC_BITS;
			acc_c[r] = {{(ACC_W-COORD_W){trans_s1[r][COORD_W-1]}}, trans_s1[r]}
				+ sh0[ACC_W-1:0] + sh1[ACC_W-1:0] + sh2[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2 <= acc_c;
		end
	end

	// Stage 3: near-plane test, magnitudes and viewport products
	assign behind_c = (acc_s2[2] < W_MIN) || (acc_s2[2] <= 0);
	assign magx_c   = acc_s2[0][ACC_W-1] ? (~acc_s2[0] + 1'b1) : acc_s2[0];
	assign magy_c   = acc_s2[1][ACC_W-1] ? (~acc_s2[1] + 1'b1) : acc_s2[1];

	always_ff @(posedge clk) begin
		if (adv) begin
			on_s3    <= ~behind_c;
			bx_s3    <= behind_axis(acc_s2[0]);
			by_s3    <= behind_axis(acc_s2[1]);
			negx_s3  <= acc_s2[0][ACC_W-1];
			negy_s3  <= ~acc_s2[1][ACC_W-1];
			halfx_s3 <= {cfg.vw, {SHIFT{1'b0}}};
			halfy_s3 <= {cfg.vh, {SHIFT{1'b0}}};
			prodx_s3 <= MP_W'(magx_c) * MP_W'(cfg.vw);
			prody_s3 <= MP_W'(magy_c) * MP_W'(cfg.vh);
			w_s3     <= acc_s2[2];
		end
	end

	// Seed the divider chain: top dividend bits form the first remainder
	always_comb begin
		logic [NUM_W-1:0]  numx, numy;
		logic [REM0_W-1:0] r0x, r0y;
		numx = {prodx_s3, {SHIFT{1'b0}}};
		numy = {prody_s3, {SHIFT{1'b0}}};
		r0x  = numx[NUM_W-1:Q_W];
		r0y  = numy[NUM_W-1:Q_W];
		seed.meta.on    = on_s3;
		seed.meta.bx    = bx_s3;
		seed.meta.by    = by_s3;
		seed.meta.negx  = negx_s3;
		seed.meta.negy  = negy_s3;
		seed.meta.halfx = halfx_s3;
		seed.meta.halfy = halfy_s3;
		seed.meta.bigx  = NUM_W'(r0x) >= NUM_W'(w_s3);
		seed.meta.bigy  = NUM_W'(r0y) >= NUM_W'(w_s3);
		seed.meta.w     = w_s3;
		seed.lx.rem     = ACC_W'(r0x);
		seed.lx.num     = numx[Q_W-1:0];
		seed.lx.quo     = '0;
		seed.ly.rem     = ACC_W'(r0y);
		seed.ly.num     = numy[Q_W-1:0];
		seed.ly.quo     = '0;
	end

	assign seed_valid = valid_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/pws_div_cell.sv -----
// ---------------------------------------------------------------------------
// pws_div_cell: one cell of the divider chain
// Produces one quotient bit for the x and the y lane and hands the partial
// results and side values to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module pws_div_cell import pws_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  d_valid,
	input  wire cell_t d,
	output logic       q_valid,
	output cell_t      q
);

	logic  valid_q;
	cell_t cell_q;

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= d_valid;
		end
	end

	// Take one division step on each lane
	always_ff @(posedge clk) begin
		if (adv) begin
			cell_q.meta <= d.meta;
			cell_q.lx   <= div_step(d.lx, d.meta.w);
			cell_q.ly   <= div_step(d.ly, d.meta.w);
		end
	end

	assign q_valid = valid_q;
	assign q       = cell_q;

endmodule

`default_nettype wire
